>>> rtl/core/pppoe_frame_classifier_core_macros.svh
// Assertion macros shared by the PPPoE frame classifier RTL.
`ifndef PPPOE_FRAME_CLASSIFIER_CORE_MACROS_SVH
`define PPPOE_FRAME_CLASSIFIER_CORE_MACROS_SVH
`ifndef SYNTHESIS
`define PFC_ASSERT(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define PFC_ASSERT_RST(lbl, clk, prop, msg) \
	lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define PFC_ASSERT(lbl, clk, rst_n, prop, msg)
`define PFC_ASSERT_RST(lbl, clk, prop, msg)
`endif
`endif

>>> rtl/core/pfc_pkg.sv
// Types and constants of the PPPoE frame classifier.
package pfc_pkg;

	localparam logic [15:0] MAX_PAYLOAD = 16'd1500;
	localparam logic [15:0] CTL_LEN_CAP = 16'd4097;
	localparam logic [10:0] MIN_FRAME   = 11'd8;

	localparam logic [7:0]  VT_REQUIRED = 8'h11;
	localparam logic [15:0] ET_DISC     = 16'h8863;
	localparam logic [15:0] ET_SESS     = 16'h8864;
	localparam logic [15:0] ET_IPV4     = 16'h0800;
	localparam logic [15:0] ET_IPV6     = 16'h86dd;
	localparam logic [7:0]  CODE_SESS   = 8'h00;
	localparam logic [7:0]  CODE_PADO   = 8'h07;
	localparam logic [7:0]  CODE_PADS   = 8'h65;
	localparam logic [7:0]  CODE_PADT   = 8'ha7;
	localparam logic [15:0] PPP_IPV4    = 16'h0021;
	localparam logic [15:0] PPP_IPV6    = 16'h0057;
	localparam logic [15:0] PPP_LCP     = 16'hc021;
	localparam logic [15:0] PPP_PAP     = 16'hc023;
	localparam logic [15:0] PPP_CHAP    = 16'hc223;
	localparam logic [15:0] PPP_IPCP    = 16'h8021;
	localparam logic [15:0] PPP_IPV6CP  = 16'h8057;
	localparam logic [3:0]  STRIP_HDR   = 4'd8;

	localparam int unsigned CFG_IDX_W = 3;
	localparam logic [CFG_IDX_W-1:0] REG_ENABLE    = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_DISC_DONE = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_LINK_RDY  = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_SRV_CHOSEN = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_SESS_IDENT = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_SERVER_MAC = 3'd5;

	localparam logic [4:0] V_DISABLED    = 5'd0;
	localparam logic [4:0] V_SHORT       = 5'd1;
	localparam logic [4:0] V_BAD_VT      = 5'd2;
	localparam logic [4:0] V_BAD_LEN     = 5'd3;
	localparam logic [4:0] V_NO_DISC     = 5'd4;
	localparam logic [4:0] V_BAD_CODE0   = 5'd5;
	localparam logic [4:0] V_SESS_ID     = 5'd6;
	localparam logic [4:0] V_MAC         = 5'd7;
	localparam logic [4:0] V_CONTROL     = 5'd8;
	localparam logic [4:0] V_IPV6        = 5'd9;
	localparam logic [4:0] V_IPV4        = 5'd10;
	localparam logic [4:0] V_UNK_PROTO   = 5'd11;
	localparam logic [4:0] V_DISC_CODE   = 5'd12;
	localparam logic [4:0] V_PADO        = 5'd13;
	localparam logic [4:0] V_PADS_PADT   = 5'd14;
	localparam logic [4:0] V_NOT_READY   = 5'd15;
	localparam logic [4:0] V_LAN_PROTO   = 5'd16;
	localparam logic [4:0] V_ENCAP       = 5'd17;
	localparam logic [4:0] V_DISC_UNSEL  = 5'd18;

	typedef struct packed {
		logic        enable;
		logic        disc_done;
		logic        link_ready;
		logic        server_chosen;
		logic [15:0] sess_ident;
		logic [47:0] server_mac;
	} cfg_t;

	typedef struct packed {
		logic        command;
		logic [15:0] eth_type;
		logic [10:0] frame_bytes;
		logic [7:0]  ver_type;
		logic [7:0]  code_byte;
		logic [15:0] rx_session;
		logic [15:0] payload_length;
		logic [15:0] ppp_proto;
		logic [47:0] src_mac;
	} item_t;

	typedef struct packed {
		logic        lan;
		logic        et_ip4;
		logic        et_ip6;
		logic        et_disc;
		logic        fb_short;
		logic        vt_bad;
		logic        plen_big;
		logic        code_pado;
		logic        code_pads;
		logic        code_padt;
		logic        code_zero;
		logic        sid_eq;
		logic        mac_eq;
		logic        proto_ctl;
		logic        proto_v6;
		logic        proto_v4;
		logic [11:0] ctl_len;
		logic [11:0] lan_len;
	} flags_t;

	typedef struct packed {
		logic [4:0]  verdict;
		logic [11:0] ctl_len;
		logic [11:0] lan_len;
		logic        ppp_v4;
	} dec_t;

	typedef struct packed {
		logic [4:0]  verdict;
		logic [11:0] out_length;
		logic [15:0] out_ppp_proto;
		logic [15:0] out_session;
		logic [15:0] out_ethertype;
		logic [47:0] dst_mac;
		logic [3:0]  strip_bytes;
	} result_t;

endpackage

>>> rtl/core/pfc_if.sv
// Header, result and configuration channel interfaces of the classifier.
interface pfc_hdr_if;
	logic        valid;
	logic        ready;
	logic        command;
	logic [15:0] eth_type;
	logic [10:0] frame_bytes;
	logic [7:0]  ver_type;
	logic [7:0]  code_byte;
	logic [15:0] rx_session;
	logic [15:0] payload_length;
	logic [15:0] ppp_proto;
	logic [47:0] src_mac;

	modport source (output valid, command, eth_type, frame_bytes, ver_type, code_byte,
		rx_session, payload_length, ppp_proto, src_mac, input ready);
	modport sink (input valid, command, eth_type, frame_bytes, ver_type, code_byte,
		rx_session, payload_length, ppp_proto, src_mac, output ready);
endinterface

interface pfc_res_if;
	logic        valid;
	logic        ready;
	logic [4:0]  verdict;
	logic [11:0] out_length;
	logic [15:0] out_ppp_proto;
	logic [15:0] out_session;
	logic [15:0] out_ethertype;
	logic [47:0] dst_mac;
	logic [3:0]  strip_bytes;

	modport source (output valid, verdict, out_length, out_ppp_proto, out_session,
		out_ethertype, dst_mac, strip_bytes, input ready);
	modport sink (input valid, verdict, out_length, out_ppp_proto, out_session,
		out_ethertype, dst_mac, strip_bytes, output ready);
endinterface

interface pfc_cfg_if;
	logic        valid;
	logic        ready;
	logic [2:0]  index;
	logic [47:0] data;

	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

>>> rtl/core/pfc_cfg.sv
// Configuration register file of the classifier.
module pfc_cfg (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          wr_vld,
	output logic                          wr_rdy,
	input  logic [pfc_pkg::CFG_IDX_W-1:0] wr_idx,
	input  logic [47:0]                   wr_data,
	output pfc_pkg::cfg_t                 cfg
);

	pfc_pkg::cfg_t cfg_q;

	assign wr_rdy = 1'b1;
	assign cfg    = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (wr_vld) begin
			unique case (wr_idx)
				pfc_pkg::REG_ENABLE:     cfg_q.enable        <= wr_data[0];
				pfc_pkg::REG_DISC_DONE:  cfg_q.disc_done     <= wr_data[0];
				pfc_pkg::REG_LINK_RDY:   cfg_q.link_ready    <= wr_data[0];
				pfc_pkg::REG_SRV_CHOSEN: cfg_q.server_chosen <= wr_data[0];
				pfc_pkg::REG_SESS_IDENT: cfg_q.sess_ident    <= wr_data[15:0];
				pfc_pkg::REG_SERVER_MAC: cfg_q.server_mac    <= wr_data;
				default: ;
			endcase
		end
	end

endmodule

>>> rtl/core/pfc_cmp.sv
// Stage 1: field compares and length arithmetic.
`include "pppoe_frame_classifier_core_macros.svh"
module pfc_cmp (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_vld,
	output logic            in_rdy,
	input  pfc_pkg::item_t  item,
	input  pfc_pkg::cfg_t   cfg,
	output logic            out_vld,
	input  logic            out_rdy,
	output pfc_pkg::flags_t flags
);

	logic            vld_s1;
	pfc_pkg::flags_t flags_s1;
	pfc_pkg::flags_t nxt;
	logic [15:0]     plen_m2;

	assign in_rdy  = !vld_s1 || out_rdy;
	assign out_vld = vld_s1;
	assign flags   = flags_s1;
	assign plen_m2 = item.payload_length - 16'd2;

	always_comb begin
		nxt.lan       = item.command;
		nxt.et_ip4    = item.eth_type == pfc_pkg::ET_IPV4;
		nxt.et_ip6    = item.eth_type == pfc_pkg::ET_IPV6;
		nxt.et_disc   = item.eth_type == pfc_pkg::ET_DISC;
		nxt.fb_short  = item.frame_bytes < pfc_pkg::MIN_FRAME;
		nxt.vt_bad    = item.ver_type != pfc_pkg::VT_REQUIRED;
		nxt.plen_big  = item.payload_length > pfc_pkg::MAX_PAYLOAD;
		nxt.code_pado = item.code_byte == pfc_pkg::CODE_PADO;
		nxt.code_pads = item.code_byte == pfc_pkg::CODE_PADS;
		nxt.code_padt = item.code_byte == pfc_pkg::CODE_PADT;
		nxt.code_zero = item.code_byte == pfc_pkg::CODE_SESS;
		nxt.sid_eq    = item.rx_session == cfg.sess_ident;
		nxt.mac_eq    = item.src_mac == cfg.server_mac;
		nxt.proto_ctl = item.ppp_proto == pfc_pkg::PPP_LCP ||
			item.ppp_proto == pfc_pkg::PPP_PAP ||
			item.ppp_proto == pfc_pkg::PPP_CHAP ||
			item.ppp_proto == pfc_pkg::PPP_IPCP ||
			item.ppp_proto == pfc_pkg::PPP_IPV6CP;
		nxt.proto_v6  = item.ppp_proto == pfc_pkg::PPP_IPV6;
		nxt.proto_v4  = item.ppp_proto == pfc_pkg::PPP_IPV4;
		if (item.payload_length < 16'd2) begin
			nxt.ctl_len = '0;
		end else if (item.payload_length > pfc_pkg::CTL_LEN_CAP) begin
			nxt.ctl_len = '1;
		end else begin
			nxt.ctl_len = plen_m2[11:0];
		end
		nxt.lan_len = {1'b0, item.frame_bytes} + 12'd2;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (in_rdy) begin
			vld_s1 <= in_vld;
		end
	end

	always_ff @(posedge clk) begin
		if (in_rdy && in_vld) begin
			flags_s1 <= nxt;
		end
	end

	`PFC_ASSERT(a_s1_hold, clk, arst_n, vld_s1 && !out_rdy |=> vld_s1 && $stable(flags_s1), "stage 1 beat changed while stalled")
	`PFC_ASSERT(a_s1_len, clk, arst_n, vld_s1 && !flags_s1.plen_big |-> flags_s1.ctl_len <= pfc_pkg::MAX_PAYLOAD[11:0], "control length beyond payload limit")

endmodule

>>> rtl/core/pfc_dec.sv
// Stage 2: priority decision of the verdict.
`include "pppoe_frame_classifier_core_macros.svh"
module pfc_dec (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_vld,
	output logic            in_rdy,
	input  pfc_pkg::flags_t flags,
	input  pfc_pkg::cfg_t   cfg,
	output logic            out_vld,
	input  logic            out_rdy,
	output pfc_pkg::dec_t   dec
);

	logic          vld_s2;
	pfc_pkg::dec_t dec_s2;
	logic [4:0]    v;

	assign in_rdy  = !vld_s2 || out_rdy;
	assign out_vld = vld_s2;
	assign dec     = dec_s2;

	always_comb begin
		if (!cfg.enable) begin
			v = pfc_pkg::V_DISABLED;
		end else if (flags.lan) begin
			if (!cfg.link_ready) begin
				v = pfc_pkg::V_NOT_READY;
			end else if (!flags.et_ip4 && !flags.et_ip6) begin
				v = pfc_pkg::V_LAN_PROTO;
			end else begin
				v = pfc_pkg::V_ENCAP;
			end
		end else if (flags.fb_short) begin
			v = pfc_pkg::V_SHORT;
		end else if (flags.vt_bad) begin
			v = pfc_pkg::V_BAD_VT;
		end else if (flags.plen_big) begin
			v = pfc_pkg::V_BAD_LEN;
		end else if (flags.et_disc) begin
			if (!flags.code_pado && !flags.code_pads && !flags.code_padt) begin
				v = pfc_pkg::V_DISC_CODE;
			end else if (flags.code_pado) begin
				v = pfc_pkg::V_PADO;
			end else if (!flags.mac_eq) begin
				v = pfc_pkg::V_MAC;
			end else if (flags.code_pads) begin
				v = pfc_pkg::V_PADS_PADT;
			end else if (!flags.sid_eq) begin
				v = pfc_pkg::V_SESS_ID;
			end else if (!cfg.server_chosen) begin
				v = pfc_pkg::V_DISC_UNSEL;
			end else begin
				v = pfc_pkg::V_PADS_PADT;
			end
		end else if (!cfg.disc_done) begin
			v = pfc_pkg::V_NO_DISC;
		end else if (!flags.code_zero) begin
			v = pfc_pkg::V_BAD_CODE0;
		end else if (!flags.sid_eq) begin
			v = pfc_pkg::V_SESS_ID;
		end else if (!flags.mac_eq) begin
			v = pfc_pkg::V_MAC;
		end else if (flags.proto_ctl) begin
			v = pfc_pkg::V_CONTROL;
		end else if (flags.proto_v6) begin
			v = pfc_pkg::V_IPV6;
		end else if (flags.proto_v4) begin
			v = pfc_pkg::V_IPV4;
		end else begin
			v = pfc_pkg::V_UNK_PROTO;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2 <= 1'b0;
		end else if (in_rdy) begin
			vld_s2 <= in_vld;
		end
	end

	always_ff @(posedge clk) begin
		if (in_rdy && in_vld) begin
			dec_s2.verdict <= v;
			dec_s2.ctl_len <= flags.ctl_len;
			dec_s2.lan_len <= flags.lan_len;
			dec_s2.ppp_v4  <= flags.et_ip4;
		end
	end

	`PFC_ASSERT(a_s2_range, clk, arst_n, vld_s2 |-> dec_s2.verdict <= pfc_pkg::V_DISC_UNSEL, "verdict code out of range")

endmodule

>>> rtl/core/pfc_fmt.sv
// Stage 3: result field formatting and output register.
`include "pppoe_frame_classifier_core_macros.svh"
module pfc_fmt (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_vld,
	output logic             in_rdy,
	input  pfc_pkg::dec_t    dec,
	input  pfc_pkg::cfg_t    cfg,
	output logic             out_vld,
	input  logic             out_rdy,
	output pfc_pkg::result_t res
);

	logic             vld_s3;
	pfc_pkg::result_t res_s3;
	pfc_pkg::result_t nxt;

	assign in_rdy  = !vld_s3 || out_rdy;
	assign out_vld = vld_s3;
	assign res     = res_s3;

	always_comb begin
		nxt         = '0;
		nxt.verdict = dec.verdict;
		case (dec.verdict) inside
			pfc_pkg::V_CONTROL: begin
				nxt.out_length  = dec.ctl_len;
				nxt.strip_bytes = pfc_pkg::STRIP_HDR;
			end
			pfc_pkg::V_IPV6, pfc_pkg::V_IPV4: begin
				nxt.strip_bytes = pfc_pkg::STRIP_HDR;
			end
			pfc_pkg::V_ENCAP: begin
				nxt.out_length    = dec.lan_len;
				nxt.out_ppp_proto = dec.ppp_v4 ? pfc_pkg::PPP_IPV4 : pfc_pkg::PPP_IPV6;
				nxt.out_session   = cfg.sess_ident;
				nxt.out_ethertype = pfc_pkg::ET_SESS;
				nxt.dst_mac       = cfg.server_mac;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s3 <= 1'b0;
		end else if (in_rdy) begin
			vld_s3 <= in_vld;
		end
	end

	always_ff @(posedge clk) begin
		if (in_rdy && in_vld) begin
			res_s3 <= nxt;
		end
	end

	`PFC_ASSERT(a_s3_encap, clk, arst_n, vld_s3 && res_s3.verdict == pfc_pkg::V_ENCAP |-> res_s3.out_ethertype == pfc_pkg::ET_SESS && res_s3.strip_bytes == 4'd0, "encapsulated beat with bad header fields")
	`PFC_ASSERT_RST(a_s3_rst, clk, !arst_n |=> !vld_s3, "result valid during reset")

endmodule

>>> rtl/core/pppoe_frame_classifier_core.sv
// Top level of the PPPoE client frame classifier.
//
//   channel  dir  width  beat
//   hdr      in   140    one parsed frame header or LAN packet descriptor
//   res      out  117    one verdict with egress/ingress fields per header
//   cfg      in   51     one register write (3-bit index, 48-bit data)
//
// Three register stages: compare, decide, format.
// One header accepted per cycle unless res stalls; the format stage register is the output.
// Backpressure on res propagates stage by stage; empty stages still fill.
// arst_n clears all stage valids and every configuration register.
// Configuration writes are registered directly, ready is always high.
module pppoe_frame_classifier_core (
	input logic       clk,
	input logic       arst_n,
	pfc_hdr_if.sink   hdr,
	pfc_res_if.source res,
	pfc_cfg_if.sink   cfg
);

	pfc_pkg::cfg_t    cfg_r;
	pfc_pkg::item_t   item;
	pfc_pkg::flags_t  flags;
	pfc_pkg::dec_t    dec;
	pfc_pkg::result_t result;
	logic             vld_1;
	logic             rdy_2;
	logic             vld_2;
	logic             rdy_3;

	assign item.command        = hdr.command;
	assign item.eth_type       = hdr.eth_type;
	assign item.frame_bytes    = hdr.frame_bytes;
	assign item.ver_type       = hdr.ver_type;
	assign item.code_byte      = hdr.code_byte;
	assign item.rx_session     = hdr.rx_session;
	assign item.payload_length = hdr.payload_length;
	assign item.ppp_proto      = hdr.ppp_proto;
	assign item.src_mac        = hdr.src_mac;

	pfc_cfg u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_vld  (cfg.valid),
		.wr_rdy  (cfg.ready),
		.wr_idx  (cfg.index),
		.wr_data (cfg.data),
		.cfg     (cfg_r)
	);

	pfc_cmp u_cmp (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_vld  (hdr.valid),
		.in_rdy  (hdr.ready),
		.item    (item),
		.cfg     (cfg_r),
		.out_vld (vld_1),
		.out_rdy (rdy_2),
		.flags   (flags)
	);

	pfc_dec u_dec (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_vld  (vld_1),
		.in_rdy  (rdy_2),
		.flags   (flags),
		.cfg     (cfg_r),
		.out_vld (vld_2),
		.out_rdy (rdy_3),
		.dec     (dec)
	);

	pfc_fmt u_fmt (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_vld  (vld_2),
		.in_rdy  (rdy_3),
		.dec     (dec),
		.cfg     (cfg_r),
		.out_vld (res.valid),
		.out_rdy (res.ready),
		.res     (result)
	);

	assign res.verdict       = result.verdict;
	assign res.out_length    = result.out_length;
	assign res.out_ppp_proto = result.out_ppp_proto;
	assign res.out_session   = result.out_session;
	assign res.out_ethertype = result.out_ethertype;
	assign res.dst_mac       = result.dst_mac;
	assign res.strip_bytes   = result.strip_bytes;

endmodule
